>>> rtl/ils_pkg.sv
`default_nettype none

package ils_pkg;

    // field widths of the channels
    localparam int OP_W       = 4;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 8;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 5;

    // default store depth and width of the cell command position (covers depth 1024)
    localparam int CAP_DEFAULT = 16;
    localparam int POS_W       = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_INSERT_AT  = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_POP_BACK   = 4'd4,
        OP_REMOVE_AT  = 4'd5,
        OP_NEXT       = 4'd6,
        OP_PREV       = 4'd7,
        OP_DUMP       = 4'd8,
        OP_DUMP_REV   = 4'd9
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_NONE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             en;   // update this cycle
        logic             ins;  // 1: open a slot at pos, 0: close the slot at pos
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> rtl/ils_if.sv
`default_nettype none

// request channel
interface ils_in_if
    import ils_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic signed [VALUE_W-1:0]    value;
    logic [POSITION_W-1:0]        position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// result channel
interface ils_out_if
    import ils_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_W-1:0]    word;
    logic [STATUS_W-1:0]          status;
    logic [LENGTH_W-1:0]          length;
    logic                         last;

    modport source (output valid, output word, output status, output length, output last,
                    input ready);
    modport sink   (input valid, input word, input status, input length, input last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/ils_cell.sv
`default_nettype none

// One slot of the store. Takes its left neighbor on insert, its right
// neighbor on removal, the new word when it is the insert slot.
module ils_cell
    import ils_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire t_cell_cmd                 i_cmd,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic signed [VALUE_W-1:0] i_left,
    input  wire logic signed [VALUE_W-1:0] i_right,
    output logic signed [VALUE_W-1:0]      o_word
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [VALUE_W-1:0] r_word;

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_cmd.ins) begin
                if (MY_IDX > i_cmd.pos) begin
                    r_word <= i_left;
                end else if (MY_IDX == i_cmd.pos) begin
                    r_word <= i_value;
                end
            end else if (MY_IDX >= i_cmd.pos) begin
                r_word <= i_right;
            end
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> rtl/indexed_list_store.sv
// Ordered store built as a row of shifting cells.
// Results are registered: a taken request moves the sequencer from idle to exec, and
// exec loads the result into the output register; a dump goes from exec to the dump
// state, which gives one entry per cycle while the output is not stalled. The sequencer
// takes one request at a time and accepts the next only after the last result is loaded.
// Reset (synchronous, active low) empties the store; cell contents are not cleared.
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ils_in_if.sink     i_in,
    ils_out_if.source  o_out
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > POSITION_W + 1) ? CW : POSITION_W + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx,   n_idx;
    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic [POSITION_W-1:0]     r_pos;

    logic                      r_o_valid, n_o_valid;
    logic signed [VALUE_W-1:0] r_o_word,  n_o_word;
    t_status                   r_o_status, n_o_status;
    logic [LENGTH_W-1:0]       r_o_length, n_o_length;
    logic                      r_o_last,  n_o_last;

    t_cell_cmd                 w_cmd;
    logic signed [VALUE_W-1:0] w_cells [CAPACITY];
    logic [IW-1:0]             w_rd_idx;
    logic signed [VALUE_W-1:0] w_rd_word;
    logic [CMP_W-1:0]          w_pe, w_ce, w_ins_pos;
    logic                      w_slot_free, w_in_acc, w_load, w_dump_last;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_o_valid || o_out.ready;
    assign w_pe        = CMP_W'(r_pos);
    assign w_ce        = CMP_W'(r_count);
    assign w_ins_pos   = (w_pe > w_ce) ? w_ce : w_pe;
    assign w_dump_last = (r_idx == r_count - CW'(1));
    assign w_rd_word   = w_cells[w_rd_idx];

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cells[g+1];
        end
        ils_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_value (r_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_cells[g])
        );
    end

    // read address: query neighbor or dump walk
    always_comb begin
        w_rd_idx = '0;
        if (r_state == S_DUMP) begin
            if (r_op == OP_DUMP) begin
                w_rd_idx = IW'(r_idx);
            end else begin
                w_rd_idx = IW'(r_count - CW'(1) - r_idx);
            end
        end else if (r_op == OP_NEXT) begin
            w_rd_idx = IW'(w_pe + CMP_W'(1));
        end else begin
            w_rd_idx = IW'(w_pe - CMP_W'(1));
        end
    end

    // sequencer: next state, cell command and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        w_cmd      = '0;
        w_load     = 1'b0;
        n_o_word   = '0;
        n_o_status = STAT_OK;
        n_o_last   = 1'b1;
        i_in.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_op == OP_DUMP || r_op == OP_DUMP_REV) && r_count != '0) begin
                    n_idx   = '0;
                    n_state = S_DUMP;
                end else if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    case (r_op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
                            if (r_count >= CAP_C) begin
                                n_o_status = STAT_FULL;
                            end else begin
                                w_cmd.en  = 1'b1;
                                w_cmd.ins = 1'b1;
                                if (r_op == OP_PUSH_FRONT) begin
                                    w_cmd.pos = '0;
                                end else if (r_op == OP_PUSH_BACK) begin
                                    w_cmd.pos = POS_W'(r_count);
                                end else begin
                                    w_cmd.pos = POS_W'(w_ins_pos);
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
                            if (r_count == '0 || (r_op == OP_REMOVE_AT && w_pe >= w_ce)) begin
                                n_o_status = STAT_EMPTY;
                            end else begin
                                w_cmd.en = 1'b1;
                                if (r_op == OP_POP_FRONT) begin
                                    w_cmd.pos = '0;
                                end else if (r_op == OP_POP_BACK) begin
                                    w_cmd.pos = POS_W'(r_count - CW'(1));
                                end else begin
                                    w_cmd.pos = POS_W'(w_pe);
                                end
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_NEXT: begin
                            if (w_pe + CMP_W'(1) < w_ce) begin
                                n_o_word = w_rd_word;
                            end else begin
                                n_o_status = STAT_NONE;
                            end
                        end
                        OP_PREV: begin
                            if (w_pe != '0 && w_pe < w_ce) begin
                                n_o_word = w_rd_word;
                            end else begin
                                n_o_status = STAT_NONE;
                            end
                        end
                        OP_DUMP, OP_DUMP_REV: begin
                            n_o_status = STAT_EMPTY;
                        end
                        default: begin
                            // undefined codes: plain ok result
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_slot_free) begin
                    w_load   = 1'b1;
                    n_o_word = w_rd_word;
                    n_o_last = w_dump_last;
                    n_idx    = r_idx + CW'(1);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_o_length = LENGTH_W'(n_count);
        if (w_load) begin
            n_o_valid = 1'b1;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_o_valid <= n_o_valid;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_in.op;
            r_value <= i_in.value;
            r_pos   <= i_in.position;
        end
        if (w_load) begin
            r_o_word   <= n_o_word;
            r_o_status <= n_o_status;
            r_o_length <= n_o_length;
            r_o_last   <= n_o_last;
        end
    end

    assign o_out.valid  = r_o_valid;
    assign o_out.word   = r_o_word;
    assign o_out.status = r_o_status;
    assign o_out.length = r_o_length;
    assign o_out.last   = r_o_last;

`ifndef SYNTH
    // store never holds more than its depth
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C) else $error("entry count above capacity");

    // a dump walk stays inside the filled slots
    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_idx < r_count)) else $error("dump index out of range");

    // a taken transaction is worked on in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC)) else $error("accepted request not executed");

    // one operation moves the count by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + CW'(1) ||
                            r_count + CW'(1) == $past(r_count)))
        else $error("entry count jumped");
`endif

endmodule

`default_nettype wire
